// ===== design/assert_macros.svh =====
// Assertion macros shared by the mesh route path generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MRPG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MRPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mrpg_pkg.sv =====
// Shared constants and controller/datapath types for the mesh route path generator.
package mrpg_pkg;

    localparam int MAX_DIM   = 8;
    localparam int DIM_W     = 4;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int NODE_W    = 6;
    localparam int DIV_STEPS = NODE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [1:0] CFG_MESH_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MESH_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ROUTE_MODE  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic emit_hop;
        logic emit_err;
    } mrpg_cmd_t;

    typedef struct packed {
        logic range_bad;
        logic same_node;
        logic div_last;
        logic out_free;
        logic hop_last;
    } mrpg_status_t;

endpackage

// ===== design/mrpg_cfg.sv =====
// Configuration registers with saturation of the mesh dimensions.
module mrpg_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [mrpg_pkg::DIM_W-1:0] cfg_data,
    output logic [mrpg_pkg::DIM_W-1:0] mesh_w,
    output logic [mrpg_pkg::DIM_W-1:0] mesh_h,
    output logic                     route_mode
);
    import mrpg_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             mode_reg, mode_next;

    assign cfg_ready = 1'b1;

    // Decode the register write
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MESH_WIDTH:  width_next  = cfg_data;
                CFG_MESH_HEIGHT: height_next = cfg_data;
                CFG_ROUTE_MODE:  mode_next   = cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_DIM);
            height_reg <= DIM_W'(MAX_DIM);
            mode_reg   <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            mode_reg   <= mode_next;
        end
    end

    // Saturate oversized dimensions
    assign mesh_w     = (width_reg  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_reg;
    assign mesh_h     = (height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_reg;
    assign route_mode = mode_reg;

endmodule

// ===== design/mrpg_datapath.sv =====
// Datapath: node split by restoring division, path walker and output register.
module mrpg_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mrpg_pkg::mrpg_cmd_t         cmd,
    output mrpg_pkg::mrpg_status_t      status,
    input  logic [mrpg_pkg::NODE_W-1:0] in_src,
    input  logic [mrpg_pkg::NODE_W-1:0] in_dst,
    input  logic [mrpg_pkg::DIM_W-1:0]  mesh_w,
    input  logic [mrpg_pkg::DIM_W-1:0]  mesh_h,
    input  logic                        route_mode,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [mrpg_pkg::NODE_W-1:0] out_from,
    output logic [mrpg_pkg::NODE_W-1:0] out_to,
    output logic                        out_last,
    output logic                        out_err
);
    import mrpg_pkg::*;

    // One restoring division step: returns {remainder, shifted quotient}
    function automatic logic [DIM_W+NODE_W-1:0] div_iter(
        input logic [DIM_W-1:0]  rem,
        input logic [NODE_W-1:0] q,
        input logic [DIM_W-1:0]  d
    );
        logic [DIM_W:0]   trial;
        logic [DIM_W-1:0] rem_new;
        logic             qbit;
        trial = {rem, q[NODE_W-1]};
        qbit  = (trial >= {1'b0, d});
        rem_new = qbit ? DIM_W'(trial - {1'b0, d}) : DIM_W'(trial);
        return {rem_new, q[NODE_W-2:0], qbit};
    endfunction

    logic [NODE_W-1:0]  src_reg, dst_reg;
    logic [NODE_W-1:0]  sq_reg, sq_next, dq_reg, dq_next;
    logic [DIM_W-1:0]   srem_reg, srem_next, drem_reg, drem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic               ovalid_reg, ovalid_next;
    logic [NODE_W-1:0]  ofrom_reg, ofrom_next, oto_reg, oto_next;
    logic               olast_reg, olast_next, oerr_reg, oerr_next;

    logic [2*DIM_W-1:0] node_count;
    logic [COORD_W-1:0] cur_r, cur_c, dst_r, dst_c, nxt_r, nxt_c;
    logic               row_eq, col_eq, parity, move_row, hop_last;
    logic [NODE_W-1:0]  step_node;
    logic [DIM_W+NODE_W-1:0] sdiv, ddiv;

    // Range check against the configured mesh size
    assign node_count = mesh_w * mesh_h;
    assign status.range_bad = ({{(2*DIM_W-NODE_W){1'b0}}, src_reg} >= node_count) ||
                              ({{(2*DIM_W-NODE_W){1'b0}}, dst_reg} >= node_count);
    assign status.same_node = (src_reg == dst_reg);
    assign status.div_last  = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign status.out_free  = !ovalid_reg || out_ready;

    // Pick the next hop from the current position
    assign cur_r  = sq_reg[COORD_W-1:0];
    assign cur_c  = srem_reg[COORD_W-1:0];
    assign dst_r  = dq_reg[COORD_W-1:0];
    assign dst_c  = drem_reg[COORD_W-1:0];
    assign row_eq = (cur_r == dst_r);
    assign col_eq = (cur_c == dst_c);
    assign parity = src_reg[0] ^ dst_reg[0] ^ cur_r[0] ^ cur_c[0];
    assign move_row = route_mode ? (!row_eq && (col_eq || parity)) : col_eq;

    always_comb
    begin
        nxt_r = cur_r;
        nxt_c = cur_c;
        if (move_row)
        begin
            if (cur_r < dst_r)
            begin
                nxt_r     = cur_r + 1'b1;
                step_node = node_reg + {{(NODE_W-DIM_W){1'b0}}, mesh_w};
            end
            else
            begin
                nxt_r     = cur_r - 1'b1;
                step_node = node_reg - {{(NODE_W-DIM_W){1'b0}}, mesh_w};
            end
        end
        else
        begin
            if (cur_c < dst_c)
            begin
                nxt_c     = cur_c + 1'b1;
                step_node = node_reg + 1'b1;
            end
            else
            begin
                nxt_c     = cur_c - 1'b1;
                step_node = node_reg - 1'b1;
            end
        end
    end

    assign hop_last        = (nxt_r == dst_r) && (nxt_c == dst_c);
    assign status.hop_last = hop_last;

    assign sdiv = div_iter(srem_reg, sq_reg, mesh_w);
    assign ddiv = div_iter(drem_reg, dq_reg, mesh_w);

    // Load, divide and walk
    always_comb
    begin
        sq_next   = sq_reg;
        dq_next   = dq_reg;
        srem_next = srem_reg;
        drem_next = drem_reg;
        cnt_next  = cnt_reg;
        node_next = node_reg;
        if (cmd.load_in)
        begin
            sq_next   = in_src;
            dq_next   = in_dst;
            srem_next = '0;
            drem_next = '0;
            cnt_next  = '0;
            node_next = in_src;
        end
        else if (cmd.div_step)
        begin
            {srem_next, sq_next} = sdiv;
            {drem_next, dq_next} = ddiv;
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.emit_hop)
        begin
            sq_next   = {{(NODE_W-COORD_W){1'b0}}, nxt_r};
            srem_next = {{(DIM_W-COORD_W){1'b0}}, nxt_c};
            node_next = step_node;
        end
    end

    // Hold or refill the output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        ofrom_next  = ofrom_reg;
        oto_next    = oto_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        if (cmd.emit_err)
        begin
            ovalid_next = 1'b1;
            ofrom_next  = '0;
            oto_next    = '0;
            olast_next  = 1'b1;
            oerr_next   = 1'b1;
        end
        else if (cmd.emit_hop)
        begin
            ovalid_next = 1'b1;
            ofrom_next  = node_reg;
            oto_next    = step_node;
            olast_next  = hop_last;
            oerr_next   = 1'b0;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            src_reg <= in_src;
            dst_reg <= in_dst;
        end
        sq_reg    <= sq_next;
        dq_reg    <= dq_next;
        srem_reg  <= srem_next;
        drem_reg  <= drem_next;
        node_reg  <= node_next;
        ofrom_reg <= ofrom_next;
        oto_reg   <= oto_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid = ovalid_reg;
    assign out_from  = ofrom_reg;
    assign out_to    = oto_reg;
    assign out_last  = olast_reg;
    assign out_err   = oerr_reg;

endmodule

// ===== design/mrpg_ctrl.sv =====
// Controller state machine: check, divide, then walk the path hop by hop.
module mrpg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output mrpg_pkg::mrpg_cmd_t    cmd,
    input  mrpg_pkg::mrpg_status_t status
);
    import mrpg_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_WALK  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Sequence one request
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.range_bad)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_err = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (status.same_node)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.emit_hop = 1'b1;
                    if (status.hop_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/mesh_route_path_generator.sv =====
// Mesh route path generator: XY or parity-adaptive hop lists on a 2D mesh.
// Usage:
//   s_* channel takes one request item: source and destination node numbers.
//   m_* channel returns the hops of that request, one item per hop, the
//   final one marked by m_tlast; a node outside the mesh gives a single item
//   with the error flag in m_tuser and m_tlast set.
//   cfg_* channel writes mesh width, mesh height and routing mode; write it
//   only while no request is in flight. It is always ready.
// Operation:
//   One request at a time. After acceptance the check state tests the range,
//   then a restoring divider splits both nodes into row and column, then
//   one hop leaves per cycle while the receiver keeps up (up to fourteen hops
//   in an 8 by 8 mesh). A same-node request returns no items.
// Reset clears the state machine and the output valid; configuration returns
//   to an 8 by 8 mesh with XY routing.
// A stalled receiver holds the output register and freezes the walk; the
//   next request is accepted while the last hop still waits.
module mesh_route_path_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] source_node, [11:6] dest_node, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] hop_from, [11:6] hop_to, [15:12] zero
    output logic        m_tlast,
    output logic        m_tuser,   // [0] range_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    import mrpg_pkg::*;

    `include "assert_macros.svh"

    mrpg_cmd_t         cmd;
    mrpg_status_t      status;
    logic [DIM_W-1:0]  mesh_w, mesh_h;
    logic              route_mode;
    logic [NODE_W-1:0] hop_from, hop_to;

    mrpg_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mesh_w     (mesh_w),
        .mesh_h     (mesh_h),
        .route_mode (route_mode)
    );

    mrpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mrpg_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_src     (s_tdata[5:0]),
        .in_dst     (s_tdata[11:6]),
        .mesh_w     (mesh_w),
        .mesh_h     (mesh_h),
        .route_mode (route_mode),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_from   (hop_from),
        .out_to     (hop_to),
        .out_last   (m_tlast),
        .out_err    (m_tuser)
    );

    assign m_tdata = {4'b0000, hop_to, hop_from};

    `MRPG_ASSERT_IMPL(a_single_emit, clk, rst_n, cmd.emit_hop, !cmd.emit_err,
                      "hop and error emitted together")
    `MRPG_ASSERT_IMPL(a_no_overwrite, clk, rst_n, m_tvalid && !m_tready,
                      !cmd.emit_hop && !cmd.emit_err, "stalled output item overwritten")
    `MRPG_ASSERT_NEXT(a_one_request, clk, rst_n, s_tvalid && s_tready, !s_tready,
                      "second request accepted while busy")
    `MRPG_ASSERT_IMPL(a_err_is_last, clk, rst_n, m_tvalid && m_tuser, m_tlast,
                      "error item not marked last")

endmodule
